>>> rtl/core/lcsbe_pkg.sv
// lcsbe_pkg: shared types, constants and the color expansion function
// for the led color spi bit encoder. No dependencies.
package lcsbe_pkg;

    localparam int LEVEL_W      = 8;
    localparam int LED_TOTAL_W  = 11;
    localparam int PAD_W        = 5;
    localparam int POS_W        = 10;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 11;
    localparam int BYTE_IDX_W   = 4;
    localparam int EXP_W        = 24;

    localparam logic [LED_TOTAL_W-1:0] MAX_LEDS = 11'd1024;
    localparam logic [PAD_W-1:0]       MAX_PAD  = 5'd16;

    localparam logic [LED_TOTAL_W-1:0] LED_TOTAL_RESET = 11'd1;
    localparam logic [PAD_W-1:0]       PAD_COUNT_RESET = 5'd8;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LED_TOTAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_COUNT = 2'd1;

    // byte positions within one led: green 0..2, red 3..5, blue 6..8
    localparam logic [BYTE_IDX_W-1:0] BYTE_G0 = 4'd0;
    localparam logic [BYTE_IDX_W-1:0] BYTE_G1 = 4'd1;
    localparam logic [BYTE_IDX_W-1:0] BYTE_G2 = 4'd2;
    localparam logic [BYTE_IDX_W-1:0] BYTE_R0 = 4'd3;
    localparam logic [BYTE_IDX_W-1:0] BYTE_R1 = 4'd4;
    localparam logic [BYTE_IDX_W-1:0] BYTE_R2 = 4'd5;
    localparam logic [BYTE_IDX_W-1:0] BYTE_B0 = 4'd6;
    localparam logic [BYTE_IDX_W-1:0] BYTE_B1 = 4'd7;
    localparam logic [BYTE_IDX_W-1:0] BYTE_B2 = 4'd8;
    localparam logic [BYTE_IDX_W-1:0] BYTE_LAST = BYTE_B2;

    // one led transaction handed to the serializer
    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
        logic [PAD_W-1:0]   pads;
        logic               closes;
    } led_job_t;

    // lsb first: data bit 0 lands in the top symbol, 1 -> 110, 0 -> 100
    function automatic logic [EXP_W-1:0] expand_level(input logic [LEVEL_W-1:0] level);
        logic [EXP_W-1:0] acc;
        acc = '0;
        for (int b = 0; b < LEVEL_W; b++) begin
            acc[EXP_W-1-3*b -: 3] = {1'b1, level[b], 1'b0};
        end
        return acc;
    endfunction

endpackage

>>> rtl/core/lcsbe_serializer.sv
// lcsbe_serializer: emits padding bytes and the nine encoded bytes of one led,
// one byte per cycle unless stalled, via a registered output. Depends on lcsbe_pkg.
module lcsbe_serializer (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       job_valid,
    input  lcsbe_pkg::led_job_t        job,
    output logic                       job_take,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_spi_byte,
    output logic                       m_run_last,
    output logic                       m_frame_end
);

    logic                                 busy_reg, busy_next;
    logic [lcsbe_pkg::PAD_W-1:0]          pad_left_reg, pad_left_next;
    logic [lcsbe_pkg::BYTE_IDX_W-1:0]     idx_reg, idx_next;
    logic [lcsbe_pkg::LEVEL_W-1:0]        red_reg, green_reg, blue_reg;
    logic [lcsbe_pkg::LEVEL_W-1:0]        red_next, green_next, blue_next;
    logic                                 closes_reg, closes_next;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       fend_reg, fend_next;

    logic                                 out_load;
    logic                                 emit;
    logic                                 in_pad;
    logic                                 finishing;
    logic [lcsbe_pkg::EXP_W-1:0]          g_exp, r_exp, b_exp;
    logic [7:0]                           color_byte;

    assign out_load  = !m_valid_reg || m_ready;
    assign emit      = busy_reg && out_load;
    assign in_pad    = (pad_left_reg != '0);
    assign finishing = emit && !in_pad && (idx_reg == lcsbe_pkg::BYTE_LAST);
    assign job_take  = job_valid && (!busy_reg || finishing);

    assign g_exp = lcsbe_pkg::expand_level(green_reg);
    assign r_exp = lcsbe_pkg::expand_level(red_reg);
    assign b_exp = lcsbe_pkg::expand_level(blue_reg);

    always_comb begin
        unique case (idx_reg)
            lcsbe_pkg::BYTE_G0: color_byte = g_exp[23:16];
            lcsbe_pkg::BYTE_G1: color_byte = g_exp[15:8];
            lcsbe_pkg::BYTE_G2: color_byte = g_exp[7:0];
            lcsbe_pkg::BYTE_R0: color_byte = r_exp[23:16];
            lcsbe_pkg::BYTE_R1: color_byte = r_exp[15:8];
            lcsbe_pkg::BYTE_R2: color_byte = r_exp[7:0];
            lcsbe_pkg::BYTE_B0: color_byte = b_exp[23:16];
            lcsbe_pkg::BYTE_B1: color_byte = b_exp[15:8];
            lcsbe_pkg::BYTE_B2: color_byte = b_exp[7:0];
            default:            color_byte = '0;
        endcase
    end

    always_comb begin
        busy_next     = busy_reg;
        pad_left_next = pad_left_reg;
        idx_next      = idx_reg;
        red_next      = red_reg;
        green_next    = green_reg;
        blue_next     = blue_reg;
        closes_next   = closes_reg;
        priority if (job_take) begin
            busy_next     = 1'b1;
            pad_left_next = job.pads;
            idx_next      = lcsbe_pkg::BYTE_G0;
            red_next      = job.red;
            green_next    = job.green;
            blue_next     = job.blue;
            closes_next   = job.closes;
        end else if (finishing) begin
            busy_next = 1'b0;
        end else if (emit) begin
            if (in_pad) begin
                pad_left_next = pad_left_reg - 1'b1;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end else begin
            // idle or output stalled: hold
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;
        fend_next    = fend_reg;
        if (out_load) begin
            m_valid_next = emit;
            byte_next    = in_pad ? 8'd0 : color_byte;
            last_next    = !in_pad && (idx_reg == lcsbe_pkg::BYTE_LAST);
            fend_next    = !in_pad && (idx_reg == lcsbe_pkg::BYTE_LAST) && closes_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
        pad_left_reg <= pad_left_next;
        idx_reg      <= idx_next;
        red_reg      <= red_next;
        green_reg    <= green_next;
        blue_reg     <= blue_next;
        closes_reg   <= closes_next;
        byte_reg     <= byte_next;
        last_reg     <= last_next;
        fend_reg     <= fend_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_spi_byte  = byte_reg;
    assign m_run_last  = last_reg;
    assign m_frame_end = fend_reg;

endmodule

>>> rtl/core/led_color_spi_bit_encoder.sv
// led_color_spi_bit_encoder: top level; config registers, frame position,
// input buffer and the byte serializer. Depends on lcsbe_pkg, lcsbe_serializer.
//
//  channel   | handshake           | payload
//  ----------+---------------------+------------------------------------------
//  input     | s_valid / s_ready   | s_red_level, s_green_level, s_blue_level
//  result    | m_valid / m_ready   | m_spi_byte, m_run_last, m_frame_end
//  config    | cfg_we              | cfg_index, cfg_data
//
// Each led gives 9 output bytes, plus pad_count zero bytes (capped at 16)
// at frame start, at one byte per cycle from the output register while
// m_ready is high. The one-entry input buffer takes the next led while the
// current one is still being sent. An input led passes through the input
// buffer and the serializer's job registers into the output register. Reset
// clears the frame position and all valid flags; m_ready low simply holds the output byte.
module led_color_spi_bit_encoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [lcsbe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lcsbe_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_red_level,
    input  logic [7:0]                          s_green_level,
    input  logic [7:0]                          s_blue_level,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [7:0]                          m_spi_byte,
    output logic                                m_run_last,
    output logic                                m_frame_end
);

    logic [lcsbe_pkg::LED_TOTAL_W-1:0] led_total_reg;
    logic [lcsbe_pkg::PAD_W-1:0]       pad_count_reg;
    logic [lcsbe_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic                              buf_valid_reg, buf_valid_next;
    lcsbe_pkg::led_job_t               buf_reg, buf_next;

    logic [lcsbe_pkg::LED_TOTAL_W-1:0] total_eff;
    logic [lcsbe_pkg::PAD_W-1:0]       pads_eff;
    logic [lcsbe_pkg::LED_TOTAL_W-1:0] pos_inc;
    logic                              closes;
    logic                              s_take;
    logic                              job_take;

    always_comb begin
        priority if (led_total_reg == '0) begin
            total_eff = lcsbe_pkg::LED_TOTAL_W'(1);
        end else if (led_total_reg > lcsbe_pkg::MAX_LEDS) begin
            total_eff = lcsbe_pkg::MAX_LEDS;
        end else begin
            total_eff = led_total_reg;
        end
    end

    assign pads_eff = (pad_count_reg > lcsbe_pkg::MAX_PAD) ? lcsbe_pkg::MAX_PAD
                                                           : pad_count_reg;
    assign pos_inc  = {1'b0, pos_reg} + 1'b1;
    // also closes the frame when the count was lowered below the position
    assign closes   = (pos_inc >= total_eff);

    assign s_ready = !buf_valid_reg;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        pos_next       = pos_reg;
        buf_valid_next = buf_valid_reg;
        buf_next       = buf_reg;
        if (job_take) begin
            buf_valid_next = 1'b0;
        end
        if (s_take) begin
            buf_valid_next  = 1'b1;
            buf_next.red    = s_red_level;
            buf_next.green  = s_green_level;
            buf_next.blue   = s_blue_level;
            buf_next.pads   = (pos_reg == '0) ? pads_eff : '0;
            buf_next.closes = closes;
            pos_next        = closes ? '0 : pos_inc[lcsbe_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_total_reg <= lcsbe_pkg::LED_TOTAL_RESET;
            pad_count_reg <= lcsbe_pkg::PAD_COUNT_RESET;
            pos_reg       <= '0;
            buf_valid_reg <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == lcsbe_pkg::REG_LED_TOTAL) begin
                led_total_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == lcsbe_pkg::REG_PAD_COUNT) begin
                pad_count_reg <= cfg_data[lcsbe_pkg::PAD_W-1:0];
            end
            pos_reg       <= pos_next;
            buf_valid_reg <= buf_valid_next;
        end
        buf_reg <= buf_next;
    end

    lcsbe_serializer u_serializer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_valid   (buf_valid_reg),
        .job         (buf_reg),
        .job_take    (job_take),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_spi_byte  (m_spi_byte),
        .m_run_last  (m_run_last),
        .m_frame_end (m_frame_end)
    );

endmodule

>>> rtl/core/lcsbe_checker.sv
// lcsbe_checker: port-level assertions for led_color_spi_bit_encoder,
// attached by bind. Depends on nothing but the top level's ports.
module lcsbe_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_spi_byte,
    input logic       m_run_last,
    input logic       m_frame_end
);

    // reset empties the output register
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // frame end only on the closing byte of an led
    a_fend_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_run_last)
        else $error("frame_end without run_last");

    // the last byte of an led is blue's low byte: symbol bits are fixed
    a_last_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_run_last |-> !m_spi_byte[0] && m_spi_byte[2] && !m_spi_byte[3]
                                  && m_spi_byte[5] && !m_spi_byte[6])
        else $error("last byte is not an encoded symbol group");

    // a stalled transaction holds its byte
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_spi_byte) && $stable(m_run_last))
        else $error("output changed while stalled");

endmodule

bind led_color_spi_bit_encoder lcsbe_checker u_lcsbe_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_spi_byte  (m_spi_byte),
    .m_run_last  (m_run_last),
    .m_frame_end (m_frame_end)
);
